// File: src/gare_pkg.sv
// package: shared types, stage codes and rate helpers for the envelope generator
package gare_pkg;

    localparam logic [1:0] STG_LOW    = 2'd0;
    localparam logic [1:0] STG_ATTACK = 2'd1;
    localparam logic [1:0] STG_HIGH   = 2'd2;
    localparam logic [1:0] STG_DECAY  = 2'd3;

    localparam logic [11:0] BEND_KNEE_1 = 12'd128;
    localparam logic [11:0] BEND_KNEE_2 = 12'd192;
    localparam logic [11:0] BEND_KNEE_3 = 12'd220;

    localparam logic [7:0] DRIVE_MIN = 8'd1;
    localparam logic [7:0] DRIVE_MAX = 8'd254;

    typedef struct packed {
        logic [1:0]  stage;
        logic        last_gate;
        logic [15:0] level;
        logic        done;
    } t_env_state;

    typedef struct packed {
        logic       gate_level;
        logic       gated_mode;
        logic [7:0] attack_rate;
        logic [7:0] decay_rate;
        logic [7:0] on_level;
        logic [7:0] off_level;
    } t_env_item;

    typedef struct packed {
        logic [7:0]  drive_value;
        logic [11:0] dac_word;
        logic        gate_thru;
        logic [1:0]  stage_now;
    } t_env_result;

    function automatic logic [11:0] bend_rate(input logic [7:0] rate);
        logic [11:0] r;
        r = {4'd0, rate};
        if (r == 12'd0) begin
            r = 12'd1;
        end
        if (r > BEND_KNEE_1) begin
            r = r + ((r - BEND_KNEE_1) << 1);
        end
        if (r > BEND_KNEE_2) begin
            r = r + ((r - BEND_KNEE_2) << 1);
        end
        if (r > BEND_KNEE_3) begin
            r = r + ((r - BEND_KNEE_3) << 1);
        end
        return r;
    endfunction

    function automatic logic [7:0] clamp_drive(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        if (v == 8'd0) begin
            c = DRIVE_MIN;
        end else if (v == 8'd255) begin
            c = DRIVE_MAX;
        end
        return c;
    endfunction

endpackage

// File: src/gare_step.sv
// envelope step: next state and result for one tick from the current state
module gare_step (
    input  gare_pkg::t_env_item   i_item,
    input  gare_pkg::t_env_state  i_state,
    output gare_pkg::t_env_state  o_state,
    output gare_pkg::t_env_result o_result
);

    logic        rise;
    logic        fall;
    logic        is_attack;
    logic [7:0]  sel_rate;
    logic [7:0]  sel_target;
    logic [11:0] step;
    logic [15:0] tgt;
    logic [15:0] cur;
    logic [16:0] up_sum;
    logic [16:0] dn_lim;
    logic [15:0] moved;
    logic        hit;
    logic [7:0]  raw;
    logic [7:0]  drive;

    assign rise = !i_state.last_gate && i_item.gate_level;
    assign fall = i_state.last_gate && !i_item.gate_level;

    assign is_attack  = (i_state.stage == gare_pkg::STG_ATTACK);
    assign sel_rate   = is_attack ? i_item.attack_rate : i_item.decay_rate;
    assign sel_target = is_attack ? i_item.on_level : i_item.off_level;
    assign step       = gare_pkg::bend_rate(sel_rate);
    assign tgt        = {sel_target, 8'h00};
    assign cur        = i_state.level;
    assign up_sum     = {1'b0, cur} + {5'd0, step};
    assign dn_lim     = {1'b0, tgt} + {5'd0, step};

    // move toward target, clamping exactly at it
    always_comb begin
        moved = cur;
        hit   = 1'b0;
        if (cur == tgt) begin
            hit = 1'b1;
        end else if (cur < tgt) begin
            if (up_sum <= {1'b0, tgt}) begin
                moved = up_sum[15:0];
            end else begin
                moved = tgt;
                hit   = 1'b1;
            end
        end else begin
            if ({1'b0, cur} >= dn_lim) begin
                moved = cur - {4'd0, step};
            end else begin
                moved = tgt;
                hit   = 1'b1;
            end
        end
    end

    always_comb begin
        o_state           = i_state;
        o_state.last_gate = i_item.gate_level;
        raw               = 8'd0;
        case (i_state.stage)
            gare_pkg::STG_LOW: begin
                raw           = i_item.off_level;
                o_state.level = {i_item.off_level, 8'h00};
                if (rise) begin
                    o_state.done  = 1'b0;
                    o_state.stage = gare_pkg::STG_ATTACK;
                end
            end
            gare_pkg::STG_ATTACK: begin
                o_state.level = moved;
                o_state.done  = i_state.done || hit;
                raw           = moved[15:8];
                if (i_item.gated_mode) begin
                    if (o_state.done) begin
                        o_state.stage = gare_pkg::STG_HIGH;
                        o_state.done  = 1'b0;
                    end
                    if (fall) begin
                        o_state.stage = gare_pkg::STG_DECAY;
                        o_state.done  = 1'b0;
                    end
                end else if (o_state.done) begin
                    o_state.stage = gare_pkg::STG_DECAY;
                    o_state.done  = 1'b0;
                end
            end
            gare_pkg::STG_HIGH: begin
                raw           = i_item.on_level;
                o_state.level = {i_item.on_level, 8'h00};
                if (fall) begin
                    o_state.done  = 1'b0;
                    o_state.stage = gare_pkg::STG_DECAY;
                end
            end
            default: begin
                o_state.level = moved;
                o_state.done  = i_state.done || hit;
                raw           = moved[15:8];
                if (rise) begin
                    o_state.stage = gare_pkg::STG_ATTACK;
                    o_state.done  = 1'b0;
                end
            end
        endcase
    end

    assign drive                = gare_pkg::clamp_drive(raw);
    assign o_result.drive_value = drive;
    assign o_result.dac_word    = {drive, 4'h0};
    assign o_result.gate_thru   = i_item.gate_level;
    assign o_result.stage_now   = o_state.stage;

endmodule

// File: src/gated_ar_envelope_generator_top.sv
// top level: input register, envelope step and result register
//
// Gated attack/release envelope generator. Each input transaction is one tick
// carrying the gate level, the mode bit and the four knob values; each tick
// produces exactly one result transaction with the clamped drive value, the
// DAC word, the gate copy and the stage after the step.
// Both channels use valid/stall: a transaction moves on a rising edge where
// valid is high and stall is low.
// A tick in the input register moves through the step into the result register.
// Throughput: one tick per cycle while the receiver does not stall, limited by
// the single envelope step between the input register and the result register.
// When the receiver stalls, the result register holds; one more tick can wait
// in the input register, after which o_stall rises until the result is taken.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// envelope to the low stage with level, gate history and done flag cleared.
module gated_ar_envelope_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_gate_level,
    input  logic        i_gated_mode,
    input  logic [7:0]  i_attack_rate,
    input  logic [7:0]  i_decay_rate,
    input  logic [7:0]  i_on_level,
    input  logic [7:0]  i_off_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_drive_value,
    output logic [11:0] o_dac_word,
    output logic        o_gate_thru,
    output logic [1:0]  o_stage_now
);

    logic                  r_in_valid;
    logic                  n_in_valid;
    gare_pkg::t_env_item   r_item;
    gare_pkg::t_env_item   in_item;
    gare_pkg::t_env_state  r_state;
    gare_pkg::t_env_state  n_state;
    gare_pkg::t_env_result step_result;
    gare_pkg::t_env_result r_result;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  in_accept;
    logic                  advance;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    assign in_item.gate_level  = i_gate_level;
    assign in_item.gated_mode  = i_gated_mode;
    assign in_item.attack_rate = i_attack_rate;
    assign in_item.decay_rate  = i_decay_rate;
    assign in_item.on_level    = i_on_level;
    assign in_item.off_level   = i_off_level;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    gare_step u_step (
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{stage: gare_pkg::STG_LOW, last_gate: 1'b0,
                             level: 16'd0, done: 1'b0};
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= in_item;
        end
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_drive_value = r_result.drive_value;
    assign o_dac_word    = r_result.dac_word;
    assign o_gate_thru   = r_result.gate_thru;
    assign o_stage_now   = r_result.stage_now;

    // a waiting tick that is not blocked always produces a result
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !(r_out_valid && i_stall)) |=> r_out_valid)
        else $error("pending tick did not reach the result register");

    // the steady stages always sit on a whole knob step
    a_steady_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stage == gare_pkg::STG_LOW || r_state.stage == gare_pkg::STG_HIGH)
        |-> (r_state.level[7:0] == 8'h00))
        else $error("low or high stage level not aligned to knob step");

    // state only moves together with a new result
    a_state_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_state))
        else $error("envelope state changed while result stalled");

endmodule

// File: tb/tb_top.sv
// testbench: random and directed ticks through the envelope generator, checked by a predictor
`timescale 1ns / 100ps

module tb_top;

    localparam int TICK_TARGET = 1875;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 120;
    localparam int TAIL_CALM   = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_gate_level = 1'b0;
    logic        i_gated_mode = 1'b0;
    logic [7:0]  i_attack_rate = 8'd0;
    logic [7:0]  i_decay_rate = 8'd0;
    logic [7:0]  i_on_level = 8'd0;
    logic [7:0]  i_off_level = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [7:0]  o_drive_value;
    logic [11:0] o_dac_word;
    logic        o_gate_thru;
    logic [1:0]  o_stage_now;

    gated_ar_envelope_generator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_gate_level  (i_gate_level),
        .i_gated_mode  (i_gated_mode),
        .i_attack_rate (i_attack_rate),
        .i_decay_rate  (i_decay_rate),
        .i_on_level    (i_on_level),
        .i_off_level   (i_off_level),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive_value (o_drive_value),
        .o_dac_word    (o_dac_word),
        .o_gate_thru   (o_gate_thru),
        .o_stage_now   (o_stage_now)
    );

    gare_pkg::t_env_item   tick_q[$];
    gare_pkg::t_env_result env_results_q[$];
    gare_pkg::t_env_result want;
    gare_pkg::t_env_item   taken;

    logic [1:0]  env_stage = gare_pkg::STG_LOW;
    logic        env_gate = 1'b0;
    logic [15:0] env_level = 16'd0;
    logic        env_done = 1'b0;

    int n_ticks = 0;
    int n_errors = 0;
    int got_count = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int steep_rate(input logic [7:0] knob);
        int r;
        r = (knob == 8'd0) ? 1 : int'(knob);
        if (r > 128) r = r + (r - 128) * 2;
        if (r > 192) r = r + (r - 192) * 2;
        if (r > 220) r = r + (r - 220) * 2;
        return r;
    endfunction

    function automatic logic [7:0] slew_level(input logic [7:0] knob, input logic [7:0] goal);
        int inc;
        int tgt;
        int cur;
        inc = steep_rate(knob);
        tgt = int'(goal) * 256;
        cur = int'(env_level);
        if (cur == tgt) begin
            env_done = 1'b1;
        end else if (cur < tgt) begin
            if (cur <= tgt - inc) begin
                cur = cur + inc;
            end else begin
                cur = tgt;
                env_done = 1'b1;
            end
        end else begin
            if (cur >= tgt + inc) begin
                cur = cur - inc;
            end else begin
                cur = tgt;
                env_done = 1'b1;
            end
        end
        env_level = cur[15:0];
        return env_level[15:8];
    endfunction

    task automatic envelope_step(input gare_pkg::t_env_item it);
        logic       rise;
        logic       fall;
        logic [7:0] raw;
        logic [7:0] drv;
        gare_pkg::t_env_result res;
        rise = !env_gate && it.gate_level;
        fall = env_gate && !it.gate_level;
        env_gate = it.gate_level;
        raw = 8'd0;
        case (env_stage)
            gare_pkg::STG_LOW: begin
                if (rise) begin
                    env_done = 1'b0;
                    env_stage = gare_pkg::STG_ATTACK;
                end
                raw = it.off_level;
                env_level = {it.off_level, 8'd0};
            end
            gare_pkg::STG_ATTACK: begin
                raw = slew_level(it.attack_rate, it.on_level);
                if (it.gated_mode) begin
                    if (env_done) begin
                        env_stage = gare_pkg::STG_HIGH;
                        env_done = 1'b0;
                    end
                    if (fall) begin
                        env_stage = gare_pkg::STG_DECAY;
                        env_done = 1'b0;
                    end
                end else if (env_done) begin
                    env_stage = gare_pkg::STG_DECAY;
                    env_done = 1'b0;
                end
            end
            gare_pkg::STG_HIGH: begin
                raw = it.on_level;
                env_level = {it.on_level, 8'd0};
                if (fall) begin
                    env_done = 1'b0;
                    env_stage = gare_pkg::STG_DECAY;
                end
            end
            default: begin
                raw = slew_level(it.decay_rate, it.off_level);
                if (rise) begin
                    env_stage = gare_pkg::STG_ATTACK;
                    env_done = 1'b0;
                end
            end
        endcase
        drv = (raw == 8'd0) ? 8'd1 : ((raw == 8'd255) ? 8'd254 : raw);
        res.drive_value = drv;
        res.dac_word = {drv, 4'd0};
        res.gate_thru = it.gate_level;
        res.stage_now = env_stage;
        env_results_q.push_back(res);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, exp_val, $time);
        n_errors++;
    endtask

    task automatic add_tick(input logic g, input logic m, input logic [7:0] a,
                            input logic [7:0] d, input logic [7:0] hi, input logic [7:0] lo);
        gare_pkg::t_env_item it;
        it.gate_level = g;
        it.gated_mode = m;
        it.attack_rate = a;
        it.decay_rate = d;
        it.on_level = hi;
        it.off_level = lo;
        tick_q.push_back(it);
    endtask

    function automatic logic [7:0] pick_rate();
        return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(140, 255));
    endfunction

    function automatic logic [7:0] pick_knob();
        if ($urandom_range(0, 5) == 0) begin
            return ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                taken.gate_level = i_gate_level;
                taken.gated_mode = i_gated_mode;
                taken.attack_rate = i_attack_rate;
                taken.decay_rate = i_decay_rate;
                taken.on_level = i_on_level;
                taken.off_level = i_off_level;
                envelope_step(taken);
                tick_q.delete(0);
            end
            if (i_valid && o_stall) begin
                // payload holds while stalled
            end else if (send_gap != 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (tick_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (tick_q.size() >= TAIL_CALM && (tick_q.size() % 300) >= 60
                         && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(0, 8);
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_gate_level <= tick_q[0].gate_level;
                i_gated_mode <= tick_q[0].gated_mode;
                i_attack_rate <= tick_q[0].attack_rate;
                i_decay_rate <= tick_q[0].decay_rate;
                i_on_level <= tick_q[0].on_level;
                i_off_level <= tick_q[0].off_level;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && got_count >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got_count <= got_count + 1;
                if (env_results_q.size() == 0) begin
                    report_mismatch("unexpected transaction, drive_value", o_drive_value, 0);
                end else begin
                    want = env_results_q.pop_front();
                    if (o_drive_value !== want.drive_value)
                        report_mismatch("drive_value", o_drive_value, want.drive_value);
                    if (o_dac_word !== want.dac_word)
                        report_mismatch("dac_word", o_dac_word, want.dac_word);
                    if (o_gate_thru !== want.gate_thru)
                        report_mismatch("gate_thru", o_gate_thru, want.gate_thru);
                    if (o_stage_now !== want.stage_now)
                        report_mismatch("stage_now", o_stage_now, want.stage_now);
                end
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
            end else if (recv_gap != 0) begin
                recv_gap--;
                i_stall <= 1'b1;
            end else if (got_count + TAIL_CALM < n_ticks && (got_count % 350) >= 70
                         && $urandom_range(0, 11) == 0) begin
                recv_gap = $urandom_range(0, 8);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        gare_pkg::t_env_item base;
        logic [63:0]         noise;
        int                  n_hi;
        int                  n_lo;
        int                  k;

        // rest, clamp at zero, rate zero, gated release
        add_tick(1'b0, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0);
        add_tick(1'b1, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0);
        add_tick(1'b1, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0);
        add_tick(1'b1, 1'b1, 8'd255, 8'd0,   8'd255, 8'd0);
        add_tick(1'b0, 1'b1, 8'd255, 8'd0,   8'd255, 8'd0);
        add_tick(1'b0, 1'b1, 8'd0,   8'd255, 8'd255, 8'd0);
        add_tick(1'b0, 1'b1, 8'd0,   8'd255, 8'd255, 8'd0);
        // attack already at target goes straight to sustain
        add_tick(1'b1, 1'b1, 8'd128, 8'd0,   8'd0,   8'd0);
        add_tick(1'b1, 1'b1, 8'd128, 8'd0,   8'd0,   8'd0);
        add_tick(1'b1, 1'b1, 8'd0,   8'd0,   8'd255, 8'd0);
        // clamp at the top, each rate knee
        add_tick(1'b0, 1'b1, 8'd0,   8'd129, 8'd255, 8'd255);
        add_tick(1'b0, 1'b1, 8'd0,   8'd193, 8'd255, 8'd255);
        add_tick(1'b0, 1'b1, 8'd0,   8'd221, 8'd255, 8'd128);
        // falling gate on the tick the attack lands wins
        add_tick(1'b1, 1'b1, 8'd255, 8'd0,   8'd255, 8'd128);
        add_tick(1'b0, 1'b1, 8'd255, 8'd0,   8'd255, 8'd128);
        // trigger mode ignores the falling gate
        add_tick(1'b0, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
        add_tick(1'b1, 1'b0, 8'd255, 8'd0,   8'd128, 8'd0);
        add_tick(1'b0, 1'b0, 8'd255, 8'd0,   8'd128, 8'd0);
        add_tick(1'b1, 1'b0, 8'd255, 8'd0,   8'd128, 8'd0);
        add_tick(1'b0, 1'b0, 8'd192, 8'd220, 8'd128, 8'd0);
        add_tick(1'b1, 1'b0, 8'd1,   8'd1,   8'd1,   8'd254);
        add_tick(1'b0, 1'b0, 8'd0,   8'd0,   8'd0,   8'd0);
        add_tick(1'b1, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
        add_tick(1'b0, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);

        while (tick_q.size() < TICK_TARGET) begin
            if ($urandom_range(0, 9) == 0) begin
                n_hi = $urandom_range(1, 10);
                for (k = 0; k < n_hi; k++) begin
                    noise = {$urandom, $urandom};
                    base = noise[33:0];
                    tick_q.push_back(base);
                end
            end else begin
                base.gated_mode = ($urandom_range(0, 3) != 0);
                base.attack_rate = pick_rate();
                base.decay_rate = pick_rate();
                base.on_level = pick_knob();
                base.off_level = pick_knob();
                n_hi = $urandom_range(1, 40);
                n_lo = $urandom_range(1, 40);
                for (k = 0; k < n_hi + n_lo; k++) begin
                    base.gate_level = (k < n_hi);
                    if ($urandom_range(0, 15) == 0) base.on_level = pick_knob();
                    if ($urandom_range(0, 15) == 0) base.off_level = pick_knob();
                    if ($urandom_range(0, 20) == 0) base.gated_mode = ~base.gated_mode;
                    tick_q.push_back(base);
                end
            end
        end
        n_ticks = tick_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tick_q.size() != 0 || env_results_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: gated_ar_envelope_generator_top.f
src/gare_pkg.sv
src/gare_step.sv
src/gated_ar_envelope_generator_top.sv
tb/tb_top.sv
